>>> design/sdtw_pkg.sv
// Package for the subsequence warping matcher: sizes, types and helpers.
package sdtw_pkg;
  localparam int PATTERN_MAX = 16;
  localparam int WINDOW_MAX  = 32;
  localparam int SYMBOL_BITS = 8;
  localparam int CNT_W = 6;
  localparam int PIDX_W = 4;
  localparam int WIDX_W = 5;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    CFG_PAT_LO  = 3'd0,
    CFG_PAT_HI  = 3'd1,
    CFG_WILD    = 3'd2,
    CFG_PLEN    = 3'd3,
    CFG_MINW    = 3'd4,
    CFG_MAXW    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_SWEEP, ST_SCAN, ST_OUT
  } state_t;

  // data handed from one cell to the next cell in the chain
  typedef struct packed {
    logic       valid;
    logic       last_col;
    logic       first_col;
    logic [SYMBOL_BITS-1:0] sym;
    cnt_t       e;
    cnt_t       n;
  } link_t;

  // returns 1 when ratio a_e/a_n is not above b_e/b_n
  function automatic logic ratio_le(cnt_t a_e, cnt_t a_n, cnt_t b_e, cnt_t b_n);
    logic [2*CNT_W-1:0] pa;
    logic [2*CNT_W-1:0] pb;
    pa = a_e * b_n;
    pb = b_e * a_n;
    return pa <= pb;
  endfunction
endpackage

>>> design/sdtw_cell.sv
// One pattern-row cell: computes its row of the warping table column by column.
module sdtw_cell import sdtw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       is_last_row,
  input  logic       wild,
  input  logic [SYMBOL_BITS-1:0] pat_sym,
  input  link_t      up_in,
  output link_t      dn_out
);
  // up_in carries the row below (j+1) for column l; this cell holds its
  // own value of column l+1 (right) and the row-below value of l+1 (diag).
  cnt_t e_right_r, n_right_r, e_diag_r, n_diag_r;
  link_t out_r;
  cnt_t e_nxt, n_nxt;
  logic m;
  cnt_t eD, lD, eR, lR, eN, lN;

  assign m = !wild && (up_in.sym != pat_sym);

  always_comb begin
    eD = e_diag_r + cnt_t'(m);  lD = n_diag_r + cnt_t'(1);
    eR = e_right_r + cnt_t'(m); lR = n_right_r + cnt_t'(1);
    eN = up_in.e + cnt_t'(m);   lN = up_in.n + cnt_t'(1);
    if (is_last_row) begin
      // bottom row: suffix mismatch count
      if (up_in.first_col) begin
        e_nxt = cnt_t'(m); n_nxt = cnt_t'(1);
      end else begin
        e_nxt = eR; n_nxt = lR;
      end
    end else if (up_in.first_col) begin
      // newest column: sum down the pattern suffix
      e_nxt = eN; n_nxt = lN;
    end else if (ratio_le(eD, lD, eR, lR)) begin
      if (ratio_le(eD, lD, eN, lN)) begin e_nxt = eD; n_nxt = lD; end
      else begin e_nxt = eN; n_nxt = lN; end
    end else begin
      if (ratio_le(eR, lR, eN, lN)) begin e_nxt = eR; n_nxt = lR; end
      else begin e_nxt = eN; n_nxt = lN; end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else begin
      out_r.valid <= up_in.valid;
    end
    out_r.last_col  <= up_in.last_col;
    out_r.first_col <= up_in.first_col;
    out_r.sym       <= up_in.sym;
    out_r.e         <= e_nxt;
    out_r.n         <= n_nxt;
    if (up_in.valid) begin
      e_right_r <= e_nxt;
      n_right_r <= n_nxt;
      e_diag_r  <= up_in.e;
      n_diag_r  <= up_in.n;
    end
  end

  assign dn_out = out_r;
endmodule

>>> design/subsequence_dtw_mismatch_matcher_core.sv
// Top level of the subsequence warping matcher: history, cell chain, result scan.
//
// Usage: each input word carries one symbol (tdata[7:0]) and series_start
// (tuser). A new series clears the count of symbols seen; history is kept.
// For each word one result word leaves: tdata holds best_errors [5:0] and
// best_length [11:6], tuser holds result_valid.
// Columns of the window enter a chain of sixteen pattern cells, newest
// first, one per cycle; each cell works one pattern row and passes its
// value, registered, to the row above. No new input word is taken until
// the result of the last one has been handed to the output register.
// Fewer than min_window symbols seen gives an invalid result without a
// sweep of the chain.
// Reset clears the handshake state and the registers to their reset
// values; the history needs no clearing. A stalled receiver holds the
// result word in the output register while the next word is worked; the
// engine waits only when a second result is ready before the first leaves.
// Write configuration only while no word is in flight.
module subsequence_dtw_mismatch_matcher_core import sdtw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // symbol
  input  logic        in_tuser,   // series_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // best_errors, best_length, zero fill
  output logic        out_tuser,  // result_valid
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [63:0] pat_lo_r, pat_hi_r;
  logic [15:0] wild_r;
  logic [4:0]  plen_r;
  logic [5:0]  minw_r, maxw_r;
  logic [SYMBOL_BITS-1:0] hist_r [WINDOW_MAX];
  logic [5:0]  seen_r, seen_nxt;
  state_t      st_r, st_nxt;
  logic [5:0]  col_r, col_nxt, scan_r, scan_nxt;
  logic [5:0]  w_r, w_nxt, lim_r, lim_nxt;
  cnt_t        be_r, be_nxt, bl_r, bl_nxt;
  logic        rv_r, rv_nxt;
  logic [5:0]  p_c, maxw_c, minw_c;
  link_t       feed;
  link_t       chain [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] row_use;
  logic        accept;
  logic        load_out;
  logic        out_v_r, out_ok_r;
  cnt_t        out_e_r, out_l_r;

  // clamped settings
  always_comb begin
    p_c = (plen_r == 5'd0) ? 6'd1 : (plen_r > 5'd16 ? 6'd16 : {1'b0, plen_r});
    maxw_c = (maxw_r == 6'd0) ? 6'd1 : (maxw_r > 6'd32 ? 6'd32 : maxw_r);
    minw_c = (minw_r == 6'd0) ? 6'd1 : minw_r;
    if (minw_c > maxw_c) minw_c = maxw_c;
  end

  assign accept = in_tvalid && in_tready;
  assign in_tready = (st_r == ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0; pat_hi_r <= '0; wild_r <= '0;
      plen_r <= 5'd1; minw_r <= 6'd1; maxw_r <= 6'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAT_LO: pat_lo_r <= cfg_data;
        CFG_PAT_HI: pat_hi_r <= cfg_data;
        CFG_WILD:   wild_r <= cfg_data[15:0];
        CFG_PLEN:   plen_r <= cfg_data[4:0];
        CFG_MINW:   minw_r <= cfg_data[5:0];
        CFG_MAXW:   maxw_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // history shift line
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WINDOW_MAX-1; i++) hist_r[i] <= hist_r[i+1];
      hist_r[WINDOW_MAX-1] <= in_tdata[SYMBOL_BITS-1:0];
    end
  end

  always_comb begin
    seen_nxt = in_tuser ? 6'd0 : seen_r;
    if (seen_nxt < 6'd32) seen_nxt = seen_nxt + 6'd1;
  end

  // feed: column l = w-1-col, bottom row enters from row p-1 cell
  always_comb begin
    feed = '0;
    feed.valid = (st_r == ST_SWEEP) && (col_r < w_r);
    feed.first_col = (col_r == 6'd0);
    feed.last_col = (col_r == w_r - 6'd1);
    feed.sym = hist_r[WIDX_W'(6'd31 - col_r)];
  end

  // chain: cell k handles pattern row PATTERN_MAX-1-k; cells for rows p and
  // above take the feed directly as their input
  assign chain[0] = feed;
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    localparam int ROW = PATTERN_MAX-1-k;
    link_t cin;
    assign row_use[k] = (6'(ROW) < p_c);
    assign cin = row_use[k] ? chain[k] : feed;
    sdtw_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .is_last_row(6'(ROW) == p_c - 6'd1),
      .wild(wild_r[ROW]),
      .pat_sym(ROW < 8 ? pat_lo_r[(ROW%8)*8 +: 8] : pat_hi_r[(ROW%8)*8 +: 8]),
      .up_in(cin),
      .dn_out(chain[k+1])
    );
  end

  // row 0 output, column index = w-1-scan; start columns l <= w-minw
  link_t top;
  assign top = chain[PATTERN_MAX];

  always_comb begin
    st_nxt = st_r; col_nxt = col_r; scan_nxt = scan_r;
    w_nxt = w_r; lim_nxt = lim_r; be_nxt = be_r; bl_nxt = bl_r; rv_nxt = rv_r;
    load_out = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (seen_nxt < minw_c) begin
            rv_nxt = 1'b0; be_nxt = '0; bl_nxt = '0; st_nxt = ST_OUT;
          end else begin
            w_nxt = (seen_nxt < maxw_c) ? seen_nxt : maxw_c;
            lim_nxt = ((seen_nxt < maxw_c) ? seen_nxt : maxw_c) - minw_c;
            col_nxt = '0; scan_nxt = '0; rv_nxt = 1'b1; st_nxt = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        col_nxt = col_r + 6'd1;
        if (top.valid) begin
          // columns arrive newest first; the first start column loads,
          // later ones take ties so the earliest column wins
          scan_nxt = scan_r + 6'd1;
          if ((w_r - 6'd1 - scan_r == lim_r) ||
              ((w_r - 6'd1 - scan_r < lim_r) &&
               ratio_le(top.e, top.n, be_r, bl_r))) begin
            be_nxt = top.e; bl_nxt = top.n;
          end
          if (top.last_col) st_nxt = ST_OUT;
        end
      end
      ST_SCAN: st_nxt = ST_OUT;
      ST_OUT: begin
        // hand the result to the output register once it is free
        if (!out_v_r || out_tready) begin
          load_out = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; seen_r <= '0; col_r <= '0; scan_r <= '0;
    end else begin
      st_r <= st_nxt; col_r <= col_nxt; scan_r <= scan_nxt;
      if (accept) seen_r <= seen_nxt;
    end
    w_r <= w_nxt; lim_r <= lim_nxt; be_r <= be_nxt; bl_r <= bl_nxt; rv_r <= rv_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load_out) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (load_out) begin
      out_ok_r <= rv_r; out_e_r <= be_r; out_l_r <= bl_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {4'd0, out_l_r, out_e_r};
  assign out_tuser = out_ok_r;
endmodule
